// ===== hw/rtl/tdau_pkg.sv =====
// shared types, constants and digit tables for the time of day advance unit
package tdau_pkg;

    localparam int AMOUNT_BITS_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MILLI_W = 10;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = MILLI_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_HOURS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MINUTES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SECONDS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MILLIS  = 3'd3;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_ADD_MILLIS  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_SECONDS = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_MINUTES = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD_HOURS   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD        = 3'd4;

    localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
    localparam logic [MIN_W-1:0]   MINUTE_MAX = 6'd59;
    localparam logic [SEC_W-1:0]   SECOND_MAX = 6'd59;
    localparam logic [MILLI_W-1:0] MILLI_MAX  = 10'd999;

    localparam int HOURS_PER_DAY    = 24;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int SECONDS_PER_MIN  = 60;
    localparam int MILLIS_PER_SEC   = 1000;

    // digit positions, least significant first
    localparam int DIGITS    = 4;
    localparam int DIG_MILLI = 0;
    localparam int DIG_SEC   = 1;
    localparam int DIG_MIN   = 2;
    localparam int DIG_HOUR  = 3;

    typedef logic [1:0] t_level;

    // reciprocal tables, exact quotient for any dividend below 2**32
    localparam int MAGIC_W = 32;
    localparam logic [MILLI_W-1:0] DIGIT_BASE [DIGITS] =
        '{10'd1000, 10'd60, 10'd60, 10'd24};
    localparam logic [MAGIC_W-1:0] DIGIT_MAGIC [DIGITS] =
        '{32'd2199023256, 32'd2290649225, 32'd2290649225, 32'd2863311531};
    localparam int DIGIT_SHIFT [DIGITS] = '{41, 37, 37, 36};

    typedef enum logic {
        KIND_ADD,
        KIND_LOAD
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic [DIGITS-1:0][MILLI_W-1:0] digit;
    } t_entry;

endpackage

// ===== hw/rtl/time_of_day_advance_unit.sv =====
// top level of the time of day advance unit
//
// input channel: i_in_valid / o_in_stall with i_operation and i_amount;
// an item adds the amount at milliseconds, seconds, minutes or hours,
// loads the start time, or (unused codes) leaves the time as it is
// output channel: o_out_valid / i_out_stall, one item per input item
// holding the whole time after that item
// configuration: i_cfg_valid / o_cfg_ready write the start registers,
// index 0 hours, 1 minutes, 2 seconds, 3 milliseconds; ready is always high
// from acceptance to o_out_valid an item passes eight register
// stages of reciprocal-multiply digit splitting, the queue write and the digit add
// throughput is one item per cycle while the receiver does not stall, set by the combinational carry add
// on the time digits
// when the receiver stalls the queue fills and o_in_stall rises once all
// QUEUE_DEPTH slots are claimed by items in flight
// reset clears the time and the start registers to zero and empties
// the pipeline
module time_of_day_advance_unit import tdau_pkg::*; #(
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [HOUR_W-1:0]      o_hours_now,
    output logic [MIN_W-1:0]       o_minutes_now,
    output logic [SEC_W-1:0]       o_seconds_now,
    output logic [MILLI_W-1:0]     o_millis_now,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

    logic                r_credit_used;
    logic [CREDIT_W-1:0] r_credit;
    logic                in_accept;
    logic                front_valid;
    t_entry              front_entry;
    logic                queue_not_empty;
    t_entry              queue_entry;
    logic                pop;

    assign o_in_stall  = (r_credit == CREDIT_W'(QUEUE_DEPTH));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit      <= '0;
            r_credit_used <= 1'b0;
        end else begin
            r_credit_used <= in_accept;
            if (in_accept && !pop) begin
                r_credit <= r_credit + 1'b1;
            end else if (pop && !in_accept) begin
                r_credit <= r_credit - 1'b1;
            end
        end
    end

    tdau_front #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_accept),
        .i_operation (i_operation),
        .i_amount    (i_amount),
        .o_valid     (front_valid),
        .o_entry     (front_entry)
    );

    tdau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .i_push_entry (front_entry),
        .i_pop        (pop),
        .o_not_empty  (queue_not_empty),
        .o_entry      (queue_entry)
    );

    tdau_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_valid (queue_not_empty),
        .i_entry       (queue_entry),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_hours_now   (o_hours_now),
        .o_minutes_now (o_minutes_now),
        .o_seconds_now (o_seconds_now),
        .o_millis_now  (o_millis_now)
    );

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(QUEUE_DEPTH))
        else $error("item credit beyond queue depth");

    a_credit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit_used && !$past(pop) |-> r_credit != '0)
        else $error("accepted item not counted");

endmodule

// ===== hw/rtl/tdau_front.sv =====
// front end: classifies items and splits the amount into time digits
module tdau_front import tdau_pkg::*; #(
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    output logic                   o_valid,
    output t_entry                 o_entry
);

    localparam int CALC_W = (AMOUNT_BITS > MILLI_W) ? AMOUNT_BITS : MILLI_W;
    localparam int PROD_W = CALC_W + MAGIC_W;

    logic              st_valid [DIGITS+1];
    logic [CALC_W-1:0] st_rem   [DIGITS+1];
    t_level            st_level [DIGITS+1];
    t_entry            st_entry [DIGITS+1];

    logic [DIGITS-1:0] r_a_valid;
    logic [PROD_W-1:0] r_a_prod  [DIGITS];
    logic [CALC_W-1:0] r_a_rem   [DIGITS];
    t_level            r_a_level [DIGITS];
    t_entry            r_a_entry [DIGITS];

    logic [DIGITS-1:0] r_b_valid;
    logic [CALC_W-1:0] r_b_rem   [DIGITS];
    t_level            r_b_level [DIGITS];
    t_entry            r_b_entry [DIGITS];

    logic is_add;

    assign is_add      = (i_operation <= OP_ADD_HOURS);
    assign st_valid[0] = i_valid;
    assign st_rem[0]   = is_add ? CALC_W'(i_amount) : '0;
    assign st_level[0] = is_add ? i_operation[1:0] : t_level'(DIG_MILLI);
    assign st_entry[0] = '{kind: (i_operation == OP_LOAD) ? KIND_LOAD : KIND_ADD,
                           digit: '0};

    for (genvar k = 0; k < DIGITS; k++) begin : g_stage
        logic [PROD_W-1:0] quo_full;
        logic [CALC_W-1:0] quo;
        logic [CALC_W-1:0] rmd;
        logic              active;
        t_entry            n_b_entry;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_valid[k] <= 1'b0;
                r_b_valid[k] <= 1'b0;
            end else begin
                r_a_valid[k] <= st_valid[k];
                r_b_valid[k] <= r_a_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_a_prod[k]  <= PROD_W'(st_rem[k]) * PROD_W'(DIGIT_MAGIC[k]);
            r_a_rem[k]   <= st_rem[k];
            r_a_level[k] <= st_level[k];
            r_a_entry[k] <= st_entry[k];
            r_b_rem[k]   <= active ? quo : r_a_rem[k];
            r_b_level[k] <= r_a_level[k];
            r_b_entry[k] <= n_b_entry;
        end

        always_comb begin
            quo_full  = r_a_prod[k] >> DIGIT_SHIFT[k];
            quo       = quo_full[CALC_W-1:0];
            rmd       = r_a_rem[k] - CALC_W'(quo * CALC_W'(DIGIT_BASE[k]));
            active    = (r_a_level[k] <= t_level'(k));
            n_b_entry = r_a_entry[k];
            if (active) begin
                n_b_entry.digit[k] = rmd[MILLI_W-1:0];
            end
        end

        assign st_valid[k+1] = r_b_valid[k];
        assign st_rem[k+1]   = r_b_rem[k];
        assign st_level[k+1] = r_b_level[k];
        assign st_entry[k+1] = r_b_entry[k];
    end

    assign o_valid = st_valid[DIGITS];
    assign o_entry = st_entry[DIGITS];

endmodule

// ===== hw/rtl/tdau_queue.sv =====
// item queue between the digit splitter and the time accumulator
module tdau_queue import tdau_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_entry,
    input  logic   i_pop,
    output logic   o_not_empty,
    output t_entry o_entry
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    t_entry             r_head;
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    always_comb begin
        n_count  = r_count;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count  <= n_count;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // head item is registered, with the incoming item written straight into it when it lands at the read position
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
        if (i_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_push_entry;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_not_empty = (r_count != '0);
    assign o_entry     = r_head;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != COUNT_W'(DEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue pop while empty");

endmodule

// ===== hw/rtl/tdau_back.sv =====
// back end: start registers, time digits, load of the clamped start time and digit-wise add with carries
module tdau_back import tdau_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_entry_valid,
    input  t_entry                 i_entry,
    output logic                   o_pop,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [HOUR_W-1:0]      o_hours_now,
    output logic [MIN_W-1:0]       o_minutes_now,
    output logic [SEC_W-1:0]       o_seconds_now,
    output logic [MILLI_W-1:0]     o_millis_now
);

    logic [HOUR_W-1:0]  r_start_hours;
    logic [MIN_W-1:0]   r_start_minutes;
    logic [SEC_W-1:0]   r_start_seconds;
    logic [MILLI_W-1:0] r_start_millis;

    logic [HOUR_W-1:0]  r_hour;
    logic [MIN_W-1:0]   r_minute;
    logic [SEC_W-1:0]   r_second;
    logic [MILLI_W-1:0] r_milli;
    logic               r_out_valid;

    logic [HOUR_W-1:0]  n_hour;
    logic [MIN_W-1:0]   n_minute;
    logic [SEC_W-1:0]   n_second;
    logic [MILLI_W-1:0] n_milli;

    logic [MILLI_W:0]   milli_sum;
    logic [SEC_W:0]     second_sum;
    logic [MIN_W:0]     minute_sum;
    logic [HOUR_W:0]    hour_sum;
    logic               c_milli;
    logic               c_second;
    logic               c_minute;
    logic               pop;

    assign pop = i_entry_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        milli_sum  = (MILLI_W+1)'(r_milli) + (MILLI_W+1)'(i_entry.digit[DIG_MILLI]);
        c_milli    = (milli_sum >= (MILLI_W+1)'(MILLIS_PER_SEC));
        second_sum = (SEC_W+1)'(r_second) + (SEC_W+1)'(i_entry.digit[DIG_SEC])
                     + (SEC_W+1)'(c_milli);
        c_second   = (second_sum >= (SEC_W+1)'(SECONDS_PER_MIN));
        minute_sum = (MIN_W+1)'(r_minute) + (MIN_W+1)'(i_entry.digit[DIG_MIN])
                     + (MIN_W+1)'(c_second);
        c_minute   = (minute_sum >= (MIN_W+1)'(MINUTES_PER_HOUR));
        hour_sum   = (HOUR_W+1)'(r_hour) + (HOUR_W+1)'(i_entry.digit[DIG_HOUR])
                     + (HOUR_W+1)'(c_minute);

        unique case (i_entry.kind)
            KIND_LOAD: begin
                n_hour   = (r_start_hours > HOUR_MAX) ? HOUR_MAX : r_start_hours;
                n_minute = (r_start_minutes > MINUTE_MAX) ? MINUTE_MAX : r_start_minutes;
                n_second = (r_start_seconds > SECOND_MAX) ? SECOND_MAX : r_start_seconds;
                n_milli  = (r_start_millis > MILLI_MAX) ? MILLI_MAX : r_start_millis;
            end
            KIND_ADD: begin
                n_milli  = c_milli ? MILLI_W'(milli_sum - (MILLI_W+1)'(MILLIS_PER_SEC))
                                   : MILLI_W'(milli_sum);
                n_second = c_second ? SEC_W'(second_sum - (SEC_W+1)'(SECONDS_PER_MIN))
                                    : SEC_W'(second_sum);
                n_minute = c_minute ? MIN_W'(minute_sum - (MIN_W+1)'(MINUTES_PER_HOUR))
                                    : MIN_W'(minute_sum);
                n_hour   = (hour_sum >= (HOUR_W+1)'(HOURS_PER_DAY))
                           ? HOUR_W'(hour_sum - (HOUR_W+1)'(HOURS_PER_DAY))
                           : HOUR_W'(hour_sum);
            end
            default: begin
                n_hour   = r_hour;
                n_minute = r_minute;
                n_second = r_second;
                n_milli  = r_milli;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_hours   <= '0;
            r_start_minutes <= '0;
            r_start_seconds <= '0;
            r_start_millis  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_HOURS:   r_start_hours   <= i_cfg_data[HOUR_W-1:0];
                CFG_START_MINUTES: r_start_minutes <= i_cfg_data[MIN_W-1:0];
                CFG_START_SECONDS: r_start_seconds <= i_cfg_data[SEC_W-1:0];
                CFG_START_MILLIS:  r_start_millis  <= i_cfg_data[MILLI_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
            r_milli     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_hour      <= n_hour;
                r_minute    <= n_minute;
                r_second    <= n_second;
                r_milli     <= n_milli;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pop         = pop;
    assign o_out_valid   = r_out_valid;
    assign o_hours_now   = r_hour;
    assign o_minutes_now = r_minute;
    assign o_seconds_now = r_second;
    assign o_millis_now  = r_milli;

    a_digits_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour <= HOUR_MAX && r_minute <= MINUTE_MAX && r_second <= SECOND_MAX
        && r_milli <= MILLI_MAX)
        else $error("time digit out of range");

    a_time_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop |=> $stable(r_hour) && $stable(r_minute) && $stable(r_second)
        && $stable(r_milli))
        else $error("time changed without an item");

endmodule

// ===== test/tb_time_of_day_advance_unit.sv =====
// self-checking testbench for the time of day advance unit
module tb_time_of_day_advance_unit;
    import tdau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 1;
    localparam int RESET_CYCLES = 6;
    localparam int LATENCY      = 10;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PLAN_LEN     = 24;

    localparam logic [AMOUNT_BITS_DEF-1:0] AMOUNT_MAX = '1;
    localparam logic [CFG_DATA_W-1:0]      DATA_MAX   = '1;

    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [MILLI_W-1:0] millis;
    } t_clock;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [OP_W-1:0]             code;
        logic [AMOUNT_BITS_DEF-1:0]  value;
        logic                        typed;
        t_clock                      want;
    } t_row;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic [OP_W-1:0]            i_operation = '0;
    logic [AMOUNT_BITS_DEF-1:0] i_amount    = '0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [HOUR_W-1:0]          o_hours_now;
    logic [MIN_W-1:0]           o_minutes_now;
    logic [SEC_W-1:0]           o_seconds_now;
    logic [MILLI_W-1:0]         o_millis_now;
    logic                       o_cfg_ready;

    // start registers and running time as the block should hold them
    logic [HOUR_W-1:0]  preset_hours   = '0;
    logic [MIN_W-1:0]   preset_minutes = '0;
    logic [SEC_W-1:0]   preset_seconds = '0;
    logic [MILLI_W-1:0] preset_millis  = '0;
    t_clock             clock_now      = '0;
    t_clock             due_times [$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  loads        = 0;
    int  day_wraps    = 0;
    int  cycles       = 0;
    int  stall_hold   = 0;
    bit  rx_free      = 1'b0;

    t_row plan [PLAN_LEN] = '{
        '{ROW_ITEM,  OP_LOAD,           0,          1, '{0,  0,  0,  0}},
        '{ROW_ITEM,  OP_ADD_MILLIS,     999,        1, '{0,  0,  0,  999}},
        '{ROW_ITEM,  OP_ADD_MILLIS,     1,          1, '{0,  0,  1,  0}},
        '{ROW_ITEM,  OP_ADD_HOURS,      23,         1, '{23, 0,  1,  0}},
        '{ROW_ITEM,  OP_ADD_SECONDS,    59,         1, '{23, 1,  0,  0}},
        '{ROW_ITEM,  OP_ADD_MINUTES,    59,         1, '{0,  0,  0,  0}},
        '{ROW_ITEM,  OP_ADD_MILLIS,     0,          1, '{0,  0,  0,  0}},
        '{ROW_ITEM,  OP_ADD_MILLIS,     AMOUNT_MAX, 0, '0},
        '{ROW_ITEM,  OP_ADD_SECONDS,    AMOUNT_MAX, 0, '0},
        '{ROW_ITEM,  OP_ADD_MINUTES,    AMOUNT_MAX, 0, '0},
        '{ROW_ITEM,  OP_ADD_HOURS,      AMOUNT_MAX, 0, '0},
        '{ROW_ITEM,  OP_UNUSED_LO,      AMOUNT_MAX, 0, '0},
        '{ROW_ITEM,  OP_UNUSED_MID,     0,          0, '0},
        '{ROW_ITEM,  OP_UNUSED_HI,      'h5A5A5,    0, '0},
        '{ROW_WRITE, CFG_START_HOURS,   DATA_MAX,   0, '0},
        '{ROW_WRITE, CFG_START_MINUTES, DATA_MAX,   0, '0},
        '{ROW_WRITE, CFG_START_SECONDS, DATA_MAX,   0, '0},
        '{ROW_WRITE, CFG_START_MILLIS,  DATA_MAX,   0, '0},
        '{ROW_WRITE, CFG_UNUSED_LO,     0,          0, '0},
        '{ROW_WRITE, CFG_UNUSED_HI,     DATA_MAX,   0, '0},
        '{ROW_ITEM,  OP_LOAD,           AMOUNT_MAX, 1, '{23, 59, 59, 999}},
        '{ROW_ITEM,  OP_ADD_MILLIS,     1,          1, '{0,  0,  0,  0}},
        '{ROW_ITEM,  OP_ADD_HOURS,      24,         1, '{0,  0,  0,  0}},
        '{ROW_ITEM,  OP_LOAD,           0,          1, '{23, 59, 59, 999}}
    };

    time_of_day_advance_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_amount      (i_amount),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hours_now   (o_hours_now),
        .o_minutes_now (o_minutes_now),
        .o_seconds_now (o_seconds_now),
        .o_millis_now  (o_millis_now),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     due_times.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    task automatic advance_clock(input logic [OP_W-1:0] op,
                                 input logic [AMOUNT_BITS_DEF-1:0] amt);
        longint unsigned carry;
        longint unsigned total;
        carry = 64'(amt);
        if (op == OP_LOAD) begin
            clock_now.hours   = (preset_hours > HOUR_MAX) ? HOUR_MAX : preset_hours;
            clock_now.minutes = (preset_minutes > MINUTE_MAX) ? MINUTE_MAX : preset_minutes;
            clock_now.seconds = (preset_seconds > SECOND_MAX) ? SECOND_MAX : preset_seconds;
            clock_now.millis  = (preset_millis > MILLI_MAX) ? MILLI_MAX : preset_millis;
            loads++;
        end else if (op <= OP_ADD_HOURS) begin
            if (op == OP_ADD_MILLIS) begin
                total = 64'(clock_now.millis) + carry;
                clock_now.millis = MILLI_W'(total % 64'(MILLIS_PER_SEC));
                carry = total / 64'(MILLIS_PER_SEC);
            end
            if (op <= OP_ADD_SECONDS) begin
                total = 64'(clock_now.seconds) + carry;
                clock_now.seconds = SEC_W'(total % 64'(SECONDS_PER_MIN));
                carry = total / 64'(SECONDS_PER_MIN);
            end
            if (op <= OP_ADD_MINUTES) begin
                total = 64'(clock_now.minutes) + carry;
                clock_now.minutes = MIN_W'(total % 64'(MINUTES_PER_HOUR));
                carry = total / 64'(MINUTES_PER_HOUR);
            end
            total = 64'(clock_now.hours) + carry;
            clock_now.hours = HOUR_W'(total % 64'(HOURS_PER_DAY));
            if (total >= 64'(HOURS_PER_DAY)) day_wraps++;
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic [AMOUNT_BITS_DEF-1:0] amt,
                             input int gap, input logic typed, input t_clock want);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_operation <= OP_W'($urandom);
            i_amount    <= AMOUNT_BITS_DEF'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_amount    <= amt;
        do @(posedge i_clk); while (o_in_stall);
        advance_clock(op, amt);
        due_times.push_back(typed ? want : clock_now);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_HOURS:   preset_hours   = data[HOUR_W-1:0];
            CFG_START_MINUTES: preset_minutes = data[MIN_W-1:0];
            CFG_START_SECONDS: preset_seconds = data[SEC_W-1:0];
            CFG_START_MILLIS:  preset_millis  = data[MILLI_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender goes quiet until every outstanding item has come back
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_times.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold--;
        end else if (!rx_free && $urandom_range(0, 99) < 30) begin
            i_out_stall <= 1'b1;
            stall_hold = pick_stall();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watch
        t_clock got;
        t_clock want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_hours_now, o_minutes_now, o_seconds_now, o_millis_now};
            if (due_times.size() == 0) begin
                report($sformatf("unexpected item %0d:%0d:%0d.%0d", got.hours,
                                 got.minutes, got.seconds, got.millis));
            end else begin
                want = due_times.pop_front();
                if (got.hours !== want.hours)
                    report($sformatf("hours %0d, want %0d", got.hours, want.hours));
                if (got.minutes !== want.minutes)
                    report($sformatf("minutes %0d, want %0d", got.minutes, want.minutes));
                if (got.seconds !== want.seconds)
                    report($sformatf("seconds %0d, want %0d", got.seconds, want.seconds));
                if (got.millis !== want.millis)
                    report($sformatf("millis %0d, want %0d", got.millis, want.millis));
            end
            results_seen++;
        end
    end

    initial begin : main
        bit                         busy;
        bit                         burst;
        int                         r;
        logic [OP_W-1:0]            op;
        logic [AMOUNT_BITS_DEF-1:0] amt;
        busy = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE) begin
                if (busy) drain_pipe();
                busy = 1'b0;
                write_reg(plan[k].code, plan[k].value[CFG_DATA_W-1:0]);
            end else begin
                send_item(plan[k].code, plan[k].value, 0, plan[k].typed, plan[k].want);
                busy = 1'b1;
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_pipe();
            case (p)
                0: begin
                    write_reg(CFG_START_HOURS, '0);
                    write_reg(CFG_START_MINUTES, '0);
                    write_reg(CFG_START_SECONDS, '0);
                    write_reg(CFG_START_MILLIS, '0);
                end
                1: begin
                    write_reg(CFG_START_HOURS, DATA_MAX);
                    write_reg(CFG_START_MINUTES, DATA_MAX);
                    write_reg(CFG_START_SECONDS, DATA_MAX);
                    write_reg(CFG_START_MILLIS, DATA_MAX);
                end
                2: begin
                    write_reg(CFG_START_HOURS, CFG_DATA_W'(HOUR_MAX));
                    write_reg(CFG_START_MINUTES, CFG_DATA_W'(MINUTE_MAX));
                    write_reg(CFG_START_SECONDS, CFG_DATA_W'(SECOND_MAX));
                    write_reg(CFG_START_MILLIS, MILLI_MAX);
                end
                default: begin
                    write_reg(CFG_START_HOURS, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
                    write_reg(CFG_START_MINUTES, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
                    write_reg(CFG_START_SECONDS, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
                    write_reg(CFG_START_MILLIS, CFG_DATA_W'($urandom_range(0, DATA_MAX)));
                end
            endcase
            write_reg(CFG_INDEX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                      CFG_DATA_W'($urandom_range(0, DATA_MAX)));

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                burst   = (i % 100) < 20;
                rx_free = burst;
                if (i == PHASE_ITEMS / 2) drain_pipe();
                r = $urandom_range(0, 99);
                if (r < 22)      op = OP_ADD_MILLIS;
                else if (r < 44) op = OP_ADD_SECONDS;
                else if (r < 62) op = OP_ADD_MINUTES;
                else if (r < 78) op = OP_ADD_HOURS;
                else if (r < 90) op = OP_LOAD;
                else             op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                r = $urandom_range(0, 9);
                if (r < 4)       amt = AMOUNT_BITS_DEF'($urandom_range(0, 15));
                else if (r < 6)  amt = AMOUNT_BITS_DEF'($urandom_range(0, 1100));
                else if (r < 8)  amt = AMOUNT_BITS_DEF'($urandom_range(0, AMOUNT_MAX));
                else if (r == 8) amt = AMOUNT_MAX;
                else             amt = '0;
                send_item(op, amt, burst ? 0 : pick_gap(), 1'b0, '0);
            end
        end
        rx_free = 1'b0;
        drain_pipe();

        $display("run covered %0d items (%0d loads, %0d day wraps) and %0d register writes",
                 items_sent, loads, day_wraps, reg_writes);
        $display("%0d results compared over %0d start-time settings, %0d mismatches",
                 results_seen, PHASES + 2, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tdau_pkg.sv
hw/rtl/tdau_front.sv
hw/rtl/tdau_queue.sv
hw/rtl/tdau_back.sv
hw/rtl/time_of_day_advance_unit.sv
test/tb_time_of_day_advance_unit.sv
